### rtl/core/cadd_pkg.sv
// ----------------------------------------------------------------------------
// cadd_pkg: shared types and constants of the complex arithmetic unit
// Operand widths, operation codes and the Q-format saturation helper.
// ----------------------------------------------------------------------------
package cadd_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * DATA_W;     // one full product
    localparam int SUM_W         = PROD_W + 1;     // sum of two products
    localparam int QUO_W         = DATA_W + 1;     // quotient bits kept by the divider
    localparam int SAT_W         = SUM_W + 1;      // saturator input width
    localparam int DIV_LAT       = QUO_W + 3;      // divider latency in cycles

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    // Clip a signed value to the DATA_W range.
    function automatic sat_t sat_fn(input logic signed [SAT_W-1:0] v);
        sat_t r;
        logic fits;
        fits = (&v[SAT_W-1:DATA_W-1]) | ~(|v[SAT_W-1:DATA_W-1]);
        if (fits)
        begin
            r.val = v[DATA_W-1:0];
            r.ovf = 1'b0;
        end
        else
        begin
            r.val = v[SAT_W-1] ? NEG_MIN : POS_MAX;
            r.ovf = 1'b1;
        end
        return r;
    endfunction

endpackage

### rtl/core/cadd_if.sv
// ----------------------------------------------------------------------------
// cadd_req_if / cadd_res_if: request and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface cadd_req_if;
    import cadd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;

    modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cadd_res_if;
    import cadd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] r_re;
    logic signed [DATA_W-1:0] r_im;
    logic                     overflow;
    logic                     div_zero;

    modport source (output valid, r_re, r_im, overflow, div_zero, input ready);
    modport sink   (input valid, r_re, r_im, overflow, div_zero, output ready);
endinterface

### rtl/core/cadd_div.sv
// ----------------------------------------------------------------------------
// cadd_div: pipelined fixed-point divider
// Restoring division, one quotient bit per stage, truncated toward zero and
// saturated. Advances only when en is high.
// ----------------------------------------------------------------------------
module cadd_div #(
    parameter int FRAC_BITS = cadd_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [cadd_pkg::SUM_W-1:0]   num,
    input  logic        [cadd_pkg::PROD_W-1:0]  den,
    output logic        [cadd_pkg::DATA_W-1:0]  quo,
    output logic                                ovf
);
    import cadd_pkg::*;

    localparam int RW = PROD_W + QUO_W;

    logic signed [SUM_W-1:0] mag_full;
    logic [PROD_W-1:0]       mag_reg;
    logic                    sgn_a_reg;
    logic [PROD_W-1:0]       den_a_reg;
    logic [RW-1:0]           nsh;
    logic                    povf_next;

    logic [RW-1:0]     rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg    [QUO_W+1];
    logic [PROD_W-1:0] den_reg  [QUO_W+1];
    logic              sgn_reg  [QUO_W+1];
    logic              povf_reg [QUO_W+1];

    logic signed [SAT_W-1:0] qs;
    logic signed [SAT_W-1:0] qv;
    sat_t                    sat_q;
    logic [DATA_W-1:0]       quo_next;
    logic                    ovf_next;

    // Stage A: take the magnitude
    assign mag_full = num[SUM_W-1] ? -num : num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mag_full[PROD_W-1:0];
            sgn_a_reg <= num[SUM_W-1];
            den_a_reg <= den;
        end
    end

    // Stage B: scale the numerator and catch quotients past the kept bits
    assign nsh       = RW'(mag_reg) << FRAC_BITS;
    assign povf_next = nsh >= (RW'(den_a_reg) << QUO_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= nsh;
            q_reg[0]    <= '0;
            den_reg[0]  <= den_a_reg;
            sgn_reg[0]  <= sgn_a_reg;
            povf_reg[0] <= povf_next;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int BIT = QUO_W - 1 - k;
        logic [RW-1:0] trial;
        logic          take;

        assign trial = RW'(den_reg[k]) << BIT;
        assign take  = rem_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - trial : rem_reg[k];
                q_reg[k+1]    <= q_reg[k] | (QUO_W'(take) << BIT);
                den_reg[k+1]  <= den_reg[k];
                sgn_reg[k+1]  <= sgn_reg[k];
                povf_reg[k+1] <= povf_reg[k];
            end
        end
    end

    // Final stage: restore the sign and saturate
    assign qs    = SAT_W'(q_reg[QUO_W]);
    assign qv    = sgn_reg[QUO_W] ? -qs : qs;
    assign sat_q = sat_fn(qv);

    always_comb
    begin
        if (povf_reg[QUO_W])
        begin
            quo_next = sgn_reg[QUO_W] ? NEG_MIN : POS_MAX;
            ovf_next = 1'b1;
        end
        else
        begin
            quo_next = sat_q.val;
            ovf_next = sat_q.ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo <= quo_next;
            ovf <= ovf_next;
        end
    end

endmodule

### rtl/core/complex_alu_add_sub_mul_div.sv
// ----------------------------------------------------------------------------
// complex_alu_add_sub_mul_div: complex add, subtract, multiply and divide
// Signed fixed-point complex arithmetic with saturation and fault flags.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per operation: func (add, subtract, multiply,
//   divide) and the operands a and b as real/imaginary parts in signed
//   fixed point with FRAC_BITS fraction bits. res returns exactly one
//   transaction per request, in order: r_re, r_im, overflow (a part was
//   clipped) and div_zero (divide by zero, result forced to zero).
//   Throughput: one transaction per cycle while the receiver does not stall.
//   Every operation passes through the full depth of the restoring divider,
//   one quotient bit per stage, so results leave in order of acceptance.
//   Every stage carries a valid bit and moves only when the output register is
//   empty or being taken. When the receiver stalls the whole pipeline holds;
//   a one-entry skid buffer in front takes the transaction already offered,
//   then req.ready drops until the stall clears. Reset empties the pipeline
//   and the skid buffer; payload registers are not reset.
// ----------------------------------------------------------------------------
module complex_alu_add_sub_mul_div #(
    parameter int FRAC_BITS = cadd_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    cadd_req_if.sink   req,
    cadd_res_if.source res
);
    import cadd_pkg::*;

    localparam int NV = DIV_LAT + 4;   // skid-fed entry, products, sums, divider, output

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } op_t;

    typedef struct packed {
        func_t             func;
        logic [DATA_W-1:0] r_re;
        logic [DATA_W-1:0] r_im;
        logic              ovf;
        logic              dz;
    } early_t;

    // Handshake and valid line
    logic          en;
    logic          accept;
    logic          skid_full_reg;
    logic          skid_full_next;
    op_t           skid_reg;
    op_t           in_op;
    logic [NV-1:0] valid_reg;

    // Stage 0
    op_t op0_reg;

    // Stage 1: products and add/sub sums
    func_t                     func1_reg;
    logic signed [PROD_W-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PROD_W-1:0]  p_bbr_reg, p_bbi_reg;
    logic signed [DATA_W:0]    as_re_reg, as_im_reg;
    logic signed [DATA_W:0]    as_re_next, as_im_next;

    // Stage 2: sums of products
    func_t                     func2_reg;
    logic signed [SUM_W-1:0]   mul_re_reg, mul_im_reg, num_re_reg, num_im_reg;
    logic [PROD_W-1:0]         den_reg;
    logic signed [DATA_W:0]    as_re2_reg, as_im2_reg;

    // Early results travel beside the divider
    logic signed [SUM_W-1:0]   mul_re_sh, mul_im_sh;
    sat_t                      sat_re, sat_im;
    early_t                    early_next;
    early_t                    e_reg [DIV_LAT];
    early_t                    e_last;

    // Divider results
    logic [DATA_W-1:0] div_re, div_im;
    logic              dovf_re, dovf_im;

    // Output register
    logic [DATA_W-1:0] r_re_reg, r_im_reg, r_re_next, r_im_next;
    logic              ovf_reg, dz_reg, ovf_next, dz_next;

    assign en     = ~valid_reg[NV-1] | res.ready;
    assign accept = req.valid & ~skid_full_reg;

    assign in_op.func = req.func;
    assign in_op.a_re = req.a_re;
    assign in_op.a_im = req.a_im;
    assign in_op.b_re = req.b_re;
    assign in_op.b_im = req.b_im;

    // Skid buffer: fill when a transaction arrives during a stall, drain on advance
    always_comb
    begin
        skid_full_next = skid_full_reg;
        if (en)
            skid_full_next = 1'b0;
        else if (accept)
            skid_full_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
            if (en)
                valid_reg <= {valid_reg[NV-2:0], skid_full_reg | accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !en)
            skid_reg <= in_op;
        if (en)
            op0_reg <= skid_full_reg ? skid_reg : in_op;
    end

    // Stage 1: all six products in parallel, plus add/sub
    always_comb
    begin
        if (func_t'(op0_reg.func) == FUNC_SUB)
        begin
            as_re_next = (DATA_W+1)'(op0_reg.a_re) - (DATA_W+1)'(op0_reg.b_re);
            as_im_next = (DATA_W+1)'(op0_reg.a_im) - (DATA_W+1)'(op0_reg.b_im);
        end
        else
        begin
            as_re_next = (DATA_W+1)'(op0_reg.a_re) + (DATA_W+1)'(op0_reg.b_re);
            as_im_next = (DATA_W+1)'(op0_reg.a_im) + (DATA_W+1)'(op0_reg.b_im);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func_t'(op0_reg.func);
            p_rr_reg  <= PROD_W'(op0_reg.a_re) * PROD_W'(op0_reg.b_re);
            p_ii_reg  <= PROD_W'(op0_reg.a_im) * PROD_W'(op0_reg.b_im);
            p_ri_reg  <= PROD_W'(op0_reg.a_re) * PROD_W'(op0_reg.b_im);
            p_ir_reg  <= PROD_W'(op0_reg.a_im) * PROD_W'(op0_reg.b_re);
            p_bbr_reg <= PROD_W'(op0_reg.b_re) * PROD_W'(op0_reg.b_re);
            p_bbi_reg <= PROD_W'(op0_reg.b_im) * PROD_W'(op0_reg.b_im);
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
    end

    // Stage 2: combine products; the squares are non-negative
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func2_reg  <= func1_reg;
            mul_re_reg <= SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
            mul_im_reg <= SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);
            num_re_reg <= SUM_W'(p_rr_reg) + SUM_W'(p_ii_reg);
            num_im_reg <= SUM_W'(p_ir_reg) - SUM_W'(p_ri_reg);
            den_reg    <= p_bbr_reg + p_bbi_reg;
            as_re2_reg <= as_re_reg;
            as_im2_reg <= as_im_reg;
        end
    end

    // Early result: saturate add/sub and multiply, flag a zero divisor
    assign mul_re_sh = mul_re_reg >>> FRAC_BITS;
    assign mul_im_sh = mul_im_reg >>> FRAC_BITS;

    always_comb
    begin
        if (func2_reg == FUNC_MUL)
        begin
            sat_re = sat_fn(SAT_W'(mul_re_sh));
            sat_im = sat_fn(SAT_W'(mul_im_sh));
        end
        else
        begin
            sat_re = sat_fn(SAT_W'(as_re2_reg));
            sat_im = sat_fn(SAT_W'(as_im2_reg));
        end
        early_next.func = func2_reg;
        early_next.r_re = sat_re.val;
        early_next.r_im = sat_im.val;
        early_next.ovf  = sat_re.ovf | sat_im.ovf;
        early_next.dz   = (func2_reg == FUNC_DIV) && (den_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg[0] <= early_next;
            for (int k = 1; k < DIV_LAT; k++)
                e_reg[k] <= e_reg[k-1];
        end
    end

    assign e_last = e_reg[DIV_LAT-1];

    cadd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_re (
        .clk (clk),
        .en  (en),
        .num (num_re_reg),
        .den (den_reg),
        .quo (div_re),
        .ovf (dovf_re)
    );

    cadd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_im (
        .clk (clk),
        .en  (en),
        .num (num_im_reg),
        .den (den_reg),
        .quo (div_im),
        .ovf (dovf_im)
    );

    // Output select: divide takes the divider results unless the divisor was zero
    always_comb
    begin
        r_re_next = e_last.r_re;
        r_im_next = e_last.r_im;
        ovf_next  = e_last.ovf;
        dz_next   = 1'b0;
        if (e_last.func == FUNC_DIV)
        begin
            if (e_last.dz)
            begin
                r_re_next = '0;
                r_im_next = '0;
                ovf_next  = 1'b0;
                dz_next   = 1'b1;
            end
            else
            begin
                r_re_next = div_re;
                r_im_next = div_im;
                ovf_next  = dovf_re | dovf_im;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_re_reg <= r_re_next;
            r_im_reg <= r_im_next;
            ovf_reg  <= ovf_next;
            dz_reg   <= dz_next;
        end
    end

    assign req.ready    = ~skid_full_reg;
    assign res.valid    = valid_reg[NV-1];
    assign res.r_re     = r_re_reg;
    assign res.r_im     = r_im_reg;
    assign res.overflow = ovf_reg;
    assign res.div_zero = dz_reg;

endmodule

### rtl/core/cadd_chk.sv
// ----------------------------------------------------------------------------
// cadd_chk: port-level checks of the complex arithmetic unit
// Watches the top-level channels and the result flags over time.
// ----------------------------------------------------------------------------
module cadd_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [cadd_pkg::DATA_W-1:0]   r_re,
    input logic [cadd_pkg::DATA_W-1:0]   r_im,
    input logic                          overflow,
    input logic                          div_zero
);
    import cadd_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(r_re) && $stable(r_im))
        else $error("stalled result changed");

    // Zero divisor forces a clean zero result
    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> r_re == '0 && r_im == '0 && !overflow)
        else $error("divide by zero result not cleared");

    // Overflow only with a clipped part
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |->
            r_re == POS_MAX || r_re == NEG_MIN || r_im == POS_MAX || r_im == NEG_MIN)
        else $error("overflow without saturated part");

    // Input backpressure only follows an output stall
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(out_valid && !out_ready))
        else $error("input stalled without output stall");

endmodule

bind complex_alu_add_sub_mul_div cadd_chk u_cadd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .r_re      (res.r_re),
    .r_im      (res.r_im),
    .overflow  (res.overflow),
    .div_zero  (res.div_zero)
);

### tb/complex_alu_add_sub_mul_div_checker.sv
// ----------------------------------------------------------------------------
// complex_alu_add_sub_mul_div_checker: result predictor and scoreboard
// Watches both channels, computes each expected result and compares in order.
// ----------------------------------------------------------------------------
module complex_alu_add_sub_mul_div_checker
    import cadd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cadd_req_if.sink req,
    cadd_res_if.sink res,
    output int   fail_count,
    output int   pending,
    output int   result_count,
    output int   ovf_count,
    output int   dz_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
        logic              dz;
    } cplx_res_t;

    cplx_res_t expected_q[$];

    function automatic logic [DATA_W-1:0] clip(input logic signed [127:0] v,
                                               inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return POS_MAX;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return NEG_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // Truncate num * 2^FB / den toward zero.
    function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                                 input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FB) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_res_t compute(input logic [1:0] f,
                                          input logic signed [31:0] ar,
                                          input logic signed [31:0] ai,
                                          input logic signed [31:0] br,
                                          input logic signed [31:0] bi);
        cplx_res_t r;
        logic signed [127:0] xr, xi, yr, yi, pre, pim, den;
        logic ovf;
        ovf = 1'b0;
        r = '0;
        xr = ar; xi = ai; yr = br; yi = bi;
        case (func_t'(f))
            FUNC_ADD:
            begin
                r.re = clip(xr + yr, ovf);
                r.im = clip(xi + yi, ovf);
            end
            FUNC_SUB:
            begin
                r.re = clip(xr - yr, ovf);
                r.im = clip(xi - yi, ovf);
            end
            FUNC_MUL:
            begin
                pre = (xr * yr - xi * yi) >>> FB;
                pim = (xr * yi + xi * yr) >>> FB;
                r.re = clip(pre, ovf);
                r.im = clip(pim, ovf);
            end
            default:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = clip(quot(xr * yr + xi * yi, den), ovf);
                    r.im = clip(quot(xi * yr - xr * yi, den), ovf);
                end
            end
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        cplx_res_t e;
        if (!rst_n)
        begin
            expected_q.delete();
            fail_count   <= 0;
            result_count <= 0;
            ovf_count    <= 0;
            dz_count     <= 0;
        end
        else
        begin
            // Drain before push so a same-cycle pair stays in order.
            if (res.valid && res.ready)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %h %h %b %b",
                             $realtime, res.r_re, res.r_im, res.overflow, res.div_zero);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.ovf) ovf_count <= ovf_count + 1;
                    if (e.dz) dz_count <= dz_count + 1;
                    if (res.r_re !== e.re || res.r_im !== e.im ||
                        res.overflow !== e.ovf || res.div_zero !== e.dz)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h ovf=%b dz=%b",
                                 $realtime, e.re, e.im, e.ovf, e.dz);
                        $display("%0t:          actual   re=%h im=%h ovf=%b dz=%b",
                                 $realtime, res.r_re, res.r_im, res.overflow,
                                 res.div_zero);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(compute(req.func, req.a_re, req.a_im,
                                             req.b_re, req.b_im));
        end
    end
endmodule

### tb/complex_alu_add_sub_mul_div_test.sv
// ----------------------------------------------------------------------------
// complex_alu_add_sub_mul_div_test: stimulus and verdict
// Directed corner operands, then bursty random traffic against a stalling sink.
// ----------------------------------------------------------------------------
module complex_alu_add_sub_mul_div_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cadd_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int TAIL_CYCLES  = DIV_LAT + 5 + 20;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    int   fail_count, pending, result_count, ovf_count, dz_count;
    int   cycle_count;
    int   sent;
    bit   stall_mode;

    cadd_req_if req ();
    cadd_res_if res ();

    complex_alu_add_sub_mul_div dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .res   (res.source)
    );

    complex_alu_add_sub_mul_div_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req.sink),
        .res          (res.sink),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .ovf_count    (ovf_count),
        .dz_count     (dz_count)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run watchdog: end the run if traffic never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver stall pattern: alternate between free-running and choppy phases.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (!rst_n)
            res.ready <= 1'b0;
        else if (!stall_mode)
            res.ready <= 1'b1;
        else
            res.ready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 30) != 0
                         || 1'b0);
    end

    // Pick an operand part: mostly random, sometimes a corner value.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return NEG_MIN;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            5: return 32'($signed(16'($urandom))) <<< 8;
            default: return $urandom;
        endcase
    endfunction

    // Offer one transaction and hold it until accepted.
    task automatic send(input logic [1:0] f, input logic [31:0] ar,
                        input logic [31:0] ai, input logic [31:0] br,
                        input logic [31:0] bi);
        req.valid <= 1'b1;
        req.func  <= f;
        req.a_re  <= ar;
        req.a_im  <= ai;
        req.b_re  <= br;
        req.b_im  <= bi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle(input int n);
        req.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        logic [1:0] f;
        logic [31:0] br, bi;
        sent        = 0;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.func    = FUNC_ADD;
        req.a_re    = '0;
        req.a_im    = '0;
        req.b_re    = '0;
        req.b_im    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each operation at the extremes, saturation, zero divisor.
        send(FUNC_ADD, POS_MAX, NEG_MIN, 32'h1, 32'hFFFF_FFFF);
        send(FUNC_ADD, NEG_MIN, POS_MAX, NEG_MIN, 32'h0);
        send(FUNC_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send(FUNC_SUB, NEG_MIN, POS_MAX, 32'h1, 32'hFFFF_FFFF);
        send(FUNC_SUB, POS_MAX, NEG_MIN, NEG_MIN, POS_MAX);
        send(FUNC_SUB, 32'h0, 32'h0, 32'h0, 32'h0);
        send(FUNC_MUL, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
        send(FUNC_MUL, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
        send(FUNC_MUL, POS_MAX, POS_MAX, NEG_MIN, POS_MAX);
        send(FUNC_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
        send(FUNC_MUL, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000);
        send(FUNC_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
        send(FUNC_DIV, NEG_MIN, POS_MAX, 32'h0, 32'h0);
        send(FUNC_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
        send(FUNC_DIV, 32'hFFFF_0000, 32'h0, 32'h0003_0000, 32'h0);
        send(FUNC_DIV, POS_MAX, POS_MAX, 32'h1, 32'h0);
        send(FUNC_DIV, NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
        send(FUNC_DIV, NEG_MIN, 32'h0, 32'h0, 32'hFFFF_FFFF);
        send(FUNC_DIV, POS_MAX, NEG_MIN, POS_MAX, NEG_MIN);
        send(FUNC_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0007_0000, 32'h0003_0000);

        // Hold off until the pipeline has fully drained once.
        wait_drain();

        // Random bursts with random gaps between them.
        while (sent < RANDOM_ITEMS + 20)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                f  = 2'($urandom);
                br = pick_part();
                bi = pick_part();
                if (f == FUNC_DIV && $urandom_range(0, 15) == 0)
                begin
                    br = '0;
                    bi = '0;
                end
                send(f, pick_part(), pick_part(), br, bi);
            end
            if ($urandom_range(0, 2) != 0)
                idle($urandom_range(1, 12));
            if ($urandom_range(0, 60) == 0)
                wait_drain();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d transactions, %0d results: %0d saturated, %0d divide by zero",
                 sent, result_count, ovf_count, dz_count);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
